[hw/rtl/kvt_pkg.sv]
// Shared constants for the key-value table: sizes, operation and status codes.
`timescale 1ns / 1ps

package kvt_pkg;

  // Table geometry
  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Port field widths
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned KEY_IN_W    = 32;
  localparam int unsigned VALUE_IN_W  = 32;
  localparam int unsigned STATUS_W    = 2;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NULL      = 2'd3;

endpackage

[hw/rtl/key_value_table_linear_search.sv]
// Top level of the key-value table: request sequencer, entry memories and result register.
`timescale 1ns / 1ps

// Bounded key-value table with a linear search. Each item carries an operation
// (add or update, remove, search), a key and a value; each item produces exactly
// one result with a status and a value. Keys and values live in two single-port
// synchronous memories of CAPACITY entries; per-entry valid bits sit in flops
// and are cleared by reset, so there is no clearing pass. An item is scanned
// with one memory read per entry; each read entry is compared against the key,
// the last one in a drain state, and a done state then writes back and loads
// the result, waiting while the result register is full and stalled. The next
// item is taken in that write-back cycle when the result register is free. The
// result register lets the result wait while the next item is already scanning.
module key_value_table_linear_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [kvt_pkg::FUNC_W-1:0]         func_i,
  input  logic [kvt_pkg::KEY_IN_W-1:0]       key_i,
  input  logic [kvt_pkg::VALUE_IN_W-1:0]     value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [kvt_pkg::STATUS_W-1:0]       status_o,
  output logic [kvt_pkg::VALUE_IN_W-1:0]     result_value_o
);
  import kvt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Control state
  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    scan_addr_q, scan_addr_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic                hit_q, hit_d;
  logic                free_fnd_q, free_fnd_d;
  logic                out_valid_q, out_valid_d;

  // Payload state
  logic [FUNC_W-1:0]     func_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [IDX_W-1:0]      hit_idx_q, hit_idx_d;
  logic [VALUE_BITS-1:0] hit_val_q, hit_val_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [VALUE_IN_W-1:0] result_q, result_d;

  // Entry memories
  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;

  logic                in_accept;
  logic                out_load;
  logic                rd_en;
  logic                hit_now;
  logic                free_now;
  logic                value_nz;
  logic                key_we;
  logic                val_we;
  logic [IDX_W-1:0]    wr_idx;

  // Handshake
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == S_IDLE) || out_load);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign rd_en      = (state_q == S_SCAN);

  // Compare the entry read in the previous cycle
  assign hit_now  = cmp_vld_q && valid_q[cmp_idx_q] && (key_rd_q == key_q);
  assign free_now = cmp_vld_q && !valid_q[cmp_idx_q];

  // Write-back decisions
  assign value_nz = (value_q != '0);
  assign val_we   = out_load && (func_q == OP_ADD) && value_nz && (hit_q || free_fnd_q);
  assign key_we   = out_load && (func_q == OP_ADD) && value_nz && !hit_q && free_fnd_q;
  assign wr_idx   = hit_q ? hit_idx_q : free_idx_q;

  // Key memory: one write or one read a cycle
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[scan_addr_q];
    end
  end

  // Value memory: one write or one read a cycle
  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[wr_idx] <= value_q;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[scan_addr_q];
    end
  end

  // Sequencer and scan bookkeeping
  always_comb begin
    state_d     = state_q;
    scan_addr_d = scan_addr_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_val_d   = hit_val_q;
    free_fnd_d  = free_fnd_q;
    free_idx_d  = free_idx_q;

    // Record the match and the lowest free slot
    if (hit_now) begin
      hit_d     = 1'b1;
      hit_idx_d = cmp_idx_q;
      hit_val_d = val_rd_q;
    end
    if (free_now && !free_fnd_q) begin
      free_fnd_d = 1'b1;
      free_idx_d = cmp_idx_q;
    end

    case (state_q)
      S_IDLE: begin
      end
      S_SCAN: begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_addr_q;
        if (scan_addr_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          scan_addr_d = scan_addr_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Start a new scan
    if (in_accept) begin
      state_d     = S_SCAN;
      scan_addr_d = '0;
      hit_d       = 1'b0;
      free_fnd_d  = 1'b0;
    end
  end

  // Result and valid-bit update
  always_comb begin
    status_d = ST_NOT_FOUND;
    result_d = '0;
    valid_d  = valid_q;
    case (func_q)
      OP_ADD: begin
        if (!value_nz) begin
          status_d = ST_NULL;
        end else if (hit_q || free_fnd_q) begin
          status_d = ST_OK;
          result_d = VALUE_IN_W'(value_q);
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_REMOVE, OP_SEARCH: begin
        if (hit_q) begin
          status_d = ST_OK;
          result_d = VALUE_IN_W'(hit_val_q);
        end
      end
      default: begin
        status_d = ST_NOT_FOUND;
      end
    endcase
    if (key_we) begin
      valid_d[free_idx_q] = 1'b1;
    end
    if (out_load && (func_q == OP_REMOVE) && hit_q) begin
      valid_d[hit_idx_q] = 1'b0;
    end
  end

  // Output register: load on write-back, drop once taken
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_addr_q <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      valid_q     <= '0;
      hit_q       <= 1'b0;
      free_fnd_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_addr_q <= scan_addr_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      valid_q     <= valid_d;
      hit_q       <= hit_d;
      free_fnd_q  <= free_fnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q  <= func_i;
      key_q   <= key_i[KEY_BITS-1:0];
      value_q <= value_i[VALUE_BITS-1:0];
    end
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
    if (out_load) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign result_value_o = result_q;

  // Keys are unique: a scan never matches twice
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_now |-> !hit_q)
    else $error("second key match within one scan");

  // An accepted item starts its scan at entry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_SCAN) && (scan_addr_q == '0))
    else $error("scan did not start at entry zero");

  // Full is reported only when every entry is in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (status_d == ST_FULL)) |-> (&valid_q))
    else $error("table full reported with a free entry");

  // A successful remove frees the matched entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (func_q == OP_REMOVE) && hit_q) |=> !valid_q[$past(hit_idx_q)])
    else $error("removed entry still valid");

endmodule

[dv/kvt_result_checker.sv]
// Checker for the key-value table: shadow table, reply prediction and reply comparison.
`timescale 1ns / 1ps

module kvt_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [kvt_pkg::FUNC_W-1:0]     func_i,
  input  logic [kvt_pkg::KEY_IN_W-1:0]   key_i,
  input  logic [kvt_pkg::VALUE_IN_W-1:0] value_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [kvt_pkg::STATUS_W-1:0]   status_i,
  input  logic [kvt_pkg::VALUE_IN_W-1:0] result_value_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             replies_o,
  output int                             full_hits_o,
  output int                             null_hits_o,
  output int                             miss_hits_o
);
  import kvt_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [VALUE_IN_W-1:0] value;
  } table_reply_t;

  // Shadow copy of the table contents
  logic [KEY_BITS-1:0]   shadow_keys  [CAPACITY];
  logic [VALUE_BITS-1:0] shadow_values[CAPACITY];
  logic                  shadow_valid [CAPACITY];

  table_reply_t table_replies_q[$];
  table_reply_t oldest_reply;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    replies_o    = 0;
    full_hits_o  = 0;
    null_hits_o  = 0;
    miss_hits_o  = 0;
  end

  // Apply one request to the shadow table and return the reply it must give
  function automatic table_reply_t apply_request(logic [FUNC_W-1:0] op,
                                                 logic [KEY_IN_W-1:0] key_in,
                                                 logic [VALUE_IN_W-1:0] value_in);
    logic [KEY_BITS-1:0]   k;
    logic [VALUE_BITS-1:0] v;
    int                    hit;
    int                    slot;
    int                    i;
    table_reply_t          r;
    k        = key_in[KEY_BITS-1:0];
    v        = value_in[VALUE_BITS-1:0];
    r.status = ST_NOT_FOUND;
    r.value  = '0;
    hit      = -1;
    slot     = -1;
    // Scan for the matching key and the lowest free slot
    for (i = 0; i < CAPACITY; i++) begin
      if (hit < 0 && shadow_valid[i] && shadow_keys[i] == k) hit = i;
      if (slot < 0 && !shadow_valid[i]) slot = i;
    end
    case (op)
      OP_ADD: begin
        if (v == '0) begin
          r.status = ST_NULL;
        end else if (hit >= 0) begin
          shadow_values[hit] = v;
          r.status = ST_OK;
          r.value  = VALUE_IN_W'(v);
        end else if (slot >= 0) begin
          shadow_keys[slot]   = k;
          shadow_values[slot] = v;
          shadow_valid[slot]  = 1'b1;
          r.status = ST_OK;
          r.value  = VALUE_IN_W'(v);
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          r.value = VALUE_IN_W'(shadow_values[hit]);
          shadow_valid[hit] = 1'b0;
          r.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        if (hit >= 0) begin
          r.value  = VALUE_IN_W'(shadow_values[hit]);
          r.status = ST_OK;
        end
      end
      default: begin
        // unused code: no change, reported as a miss
      end
    endcase
    return r;
  endfunction

  // Compare accepted replies first, then predict for the accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) shadow_valid[i] = 1'b0;
      table_replies_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        replies_o++;
        if (status_i == ST_FULL) full_hits_o++;
        if (status_i == ST_NULL) null_hits_o++;
        if (status_i == ST_NOT_FOUND) miss_hits_o++;
        if (table_replies_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: reply with none expected: status %0d value %08h",
                   $time, status_i, result_value_i);
        end else begin
          oldest_reply = table_replies_q.pop_front();
          if (status_i !== oldest_reply.status) begin
            fail_count_o++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, oldest_reply.status, status_i);
          end
          if (result_value_i !== oldest_reply.value) begin
            fail_count_o++;
            $display("%0t: result_value mismatch, expected %08h, actual %08h",
                     $time, oldest_reply.value, result_value_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        table_replies_q.push_back(apply_request(func_i, key_i, value_i));
      end
      pending_o = table_replies_q.size();
    end
  end

endmodule

[dv/tb_key_value_table_linear_search.sv]
// Testbench top for the key-value table: clock, reset, request stimulus, reply stalls, verdict.
`timescale 1ns / 1ps

module tb_key_value_table_linear_search;
  import kvt_pkg::*;

  // Operation code the block does not define
  localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;
  localparam int                POOL_MAX  = 24;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [FUNC_W-1:0]     func_i         = OP_ADD;
  logic [KEY_IN_W-1:0]   key_i          = '0;
  logic [VALUE_IN_W-1:0] value_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [VALUE_IN_W-1:0] result_value_o;

  int fail_count;
  int pending;
  int replies;
  int full_hits;
  int null_hits;
  int miss_hits;

  bit                  no_idle = 1'b0;
  int                  stall_left = 0;
  int                  sent = 0;
  int                  directed = 0;
  logic [KEY_IN_W-1:0] key_pool[POOL_MAX];

  always #1 clk_i = ~clk_i;

  key_value_table_linear_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .result_value_o(result_value_o)
  );

  kvt_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .func_i        (func_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .result_value_i(result_value_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .replies_o     (replies),
    .full_hits_o   (full_hits),
    .null_hits_o   (null_hits),
    .miss_hits_o   (miss_hits)
  );

  // Idle gap before a request: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Drive one request and hold it until the block takes it
  task automatic send_request(logic [FUNC_W-1:0] op, logic [KEY_IN_W-1:0] k,
                              logic [VALUE_IN_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    func_i     = op;
    key_i      = k;
    value_i    = v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Stop sending until every reply has come back
  task automatic drain_replies();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Stall the reply side in bursts: mostly short, a few long
  always @(negedge clk_i) begin
    if (!rst_ni || no_idle) begin
      out_stall_i = 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall_i) begin
      out_stall_i = 1'b0;
      stall_left  = $urandom_range(0, 12);
    end else begin
      out_stall_i = 1'b1;
      stall_left  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                 : $urandom_range(15, 80);
    end
  end

  initial begin
    int add_pct;
    int rem_pct;
    int pool_n;
    int sel;
    logic [FUNC_W-1:0]     op;
    logic [KEY_IN_W-1:0]   k;
    logic [VALUE_IN_W-1:0] v;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: key extremes, null value, update, remove, misses, unused code
    send_request(OP_ADD,    32'h0000_0000, 32'h0000_0001);
    send_request(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_SEARCH, 32'h0000_0000, 32'hDEAD_BEEF);
    send_request(OP_ADD,    32'h0000_0007, 32'h0000_0000);
    send_request(OP_ADD,    32'h0000_0000, 32'h5A5A_5A5A);
    send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_SEARCH, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'h1234_5678);
    // Fill the remaining slots, then hit the full table
    for (int i = 0; i < CAPACITY - 1; i++) begin
      send_request(OP_ADD, 32'hA5A5_0100 + i, 32'h8000_0000 | i);
    end
    send_request(OP_ADD,    32'h0BAD_F00D, 32'h0000_0042);
    send_request(OP_ADD,    32'hFFFF_FFFF, 32'h1234_5678);
    send_request(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);
    directed = sent;
    drain_replies();

    // Random: phases that fill, churn and drain the table over a key pool
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      no_idle = (ph == 2);
      pool_n  = (ph % 2 == 1) ? 8 : POOL_MAX;
      case (ph)
        0:       add_pct = 70;
        3:       add_pct = 65;
        5:       add_pct = 15;
        default: add_pct = 40;
      endcase
      rem_pct = (ph == 5) ? 55 : (97 - add_pct) / 2;
      for (int n = 0; n < 190; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < add_pct) op = OP_ADD;
        else if (sel < add_pct + rem_pct) op = OP_REMOVE;
        else if (sel < 97) op = OP_SEARCH;
        else op = OP_UNUSED;
        k = ($urandom_range(0, 99) < 10) ? $urandom
                                         : key_pool[$urandom_range(0, pool_n - 1)];
        v = ($urandom_range(0, 99) < 6) ? '0 : $urandom;
        send_request(op, k, v);
      end
      if (ph == 2) drain_replies();
    end
    no_idle = 1'b0;

    // Wait for the last replies, then a margin for anything stray
    drain_replies();
    repeat (40) @(negedge clk_i);

    $display("Ran %0d requests (%0d directed) and checked %0d replies.",
             sent, directed, replies);
    $display("Replies seen: %0d table full, %0d null value, %0d key miss.",
             full_hits, null_hits, miss_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("** key_value_table_linear_search: PASSED **");
    end else begin
      $display("** key_value_table_linear_search: FAILED **");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1500000;
    $display("** key_value_table_linear_search: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/kvt_pkg.sv
hw/rtl/key_value_table_linear_search.sv
dv/kvt_result_checker.sv
dv/tb_key_value_table_linear_search.sv
